// ===== src/rhp_pkg.sv =====
// Shared types and constants for the RTP header parser.
`timescale 1ns / 1ps

package rhp_pkg;

    localparam int COUNT_W  = 18;
    localparam int SKIP_W   = 18;
    localparam int PLEN_W   = 16;
    localparam int TDATA_W  = 120;

    localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] FIXED_HEADER_BYTES = COUNT_W'(12);
    localparam logic [COUNT_W-1:0] IDX_SEQ_END        = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] IDX_TS_END         = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] IDX_HDR_LAST       = FIXED_HEADER_BYTES - COUNT_W'(1);
    localparam logic [SKIP_W-1:0]  EXT_HDR_BYTES      = SKIP_W'(4);
    localparam logic [SKIP_W-1:0]  EXT_LEN_HI         = SKIP_W'(2);
    localparam logic [SKIP_W-1:0]  EXT_LEN_LO         = SKIP_W'(1);
    localparam logic [PLEN_W-1:0]  PLEN_MAX           = {PLEN_W{1'b1}};
    localparam logic [1:0]         RTP_VERSION        = 2'd2;

    typedef enum logic [5:0] {
        PH_FIXED    = 6'b000001,
        PH_CSRC     = 6'b000010,
        PH_EXT_HDR  = 6'b000100,
        PH_EXT_BODY = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_DISCARD  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT       = 2'd1,
        ST_BAD_VERSION = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic              byte_valid;
        logic [7:0]        payload_byte;
        logic              end_of_packet;
        status_t           status;
        logic              marker;
        logic [6:0]        payload_type;
        logic [15:0]       sequence_res;
        logic [31:0]       timestamp;
        logic [31:0]       ssrc;
        logic [PLEN_W-1:0] payload_length;
    } res_t;

endpackage

// ===== src/rhp_input_stage.sv =====
// Input register for packet bytes.
`timescale 1ns / 1ps

module rhp_input_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rhp_pkg::item_t s_item,
    input  logic          advance,
    output logic          in_valid,
    output rhp_pkg::item_t in_item
);
    import rhp_pkg::*;

    logic  in_valid_reg;
    item_t item_reg;

    assign s_tready = !in_valid_reg || advance;
    assign in_valid = in_valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    // a held item must not move or change until the core takes it
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("input item dropped or changed while waiting");

endmodule

// ===== src/rhp_parse_core.sv =====
// Header parse state and per-byte result logic.
`timescale 1ns / 1ps

module rhp_parse_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  rhp_pkg::item_t item,
    output logic           has_result,
    output rhp_pkg::res_t  res
);
    import rhp_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [15:0]        first_reg,  first_next;
    logic [15:0]        seq_reg,    seq_next;
    logic [31:0]        time_reg,   time_next;
    logic [31:0]        source_reg, source_next;
    logic [SKIP_W-1:0]  skip_reg,   skip_next;
    logic [PLEN_W-1:0]  pc_reg,     pc_next;

    logic [7:0]         b;
    logic [COUNT_W-1:0] idx;
    logic               fwd;
    logic [SKIP_W-1:0]  skip_dec;
    logic [15:0]        ext_words;
    logic [3:0]         cc;
    status_t            status;

    always_comb begin
        b        = item.data_byte;
        idx      = count_reg;
        fwd      = 1'b0;
        cc       = first_reg[11:8];
        skip_dec = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;
        ext_words = {pc_reg[7:0], b};

        phase_next  = phase_reg;
        count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        first_next  = first_reg;
        seq_next    = seq_reg;
        time_next   = time_reg;
        source_next = source_reg;
        skip_next   = skip_reg;
        pc_next     = pc_reg;

        case (phase_reg)
            PH_FIXED: begin
                if (idx == '0) begin
                    first_next = {b, 8'h00};
                    if (b[7:6] != RTP_VERSION) begin
                        phase_next = PH_DISCARD;
                    end
                end else if (idx == COUNT_W'(1)) begin
                    first_next = {first_reg[15:8], b};
                end else if (idx < IDX_SEQ_END) begin
                    seq_next = {seq_reg[7:0], b};
                end else if (idx < IDX_TS_END) begin
                    time_next = {time_reg[23:0], b};
                end else begin
                    source_next = {source_reg[23:0], b};
                end
                // header complete: CSRC list, then extension, then payload
                if (idx == IDX_HDR_LAST) begin
                    if (cc != 4'd0) begin
                        phase_next = PH_CSRC;
                        skip_next  = {{(SKIP_W-6){1'b0}}, cc, 2'b00};
                    end else if (first_reg[12]) begin
                        phase_next = PH_EXT_HDR;
                        skip_next  = EXT_HDR_BYTES;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_CSRC: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    if (first_reg[12]) begin
                        phase_next = PH_EXT_HDR;
                        skip_next  = EXT_HDR_BYTES;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXT_HDR: begin
                if (skip_reg == EXT_LEN_HI) begin
                    // payload counter is idle here; it parks the length high byte
                    pc_next   = {8'h00, b};
                    skip_next = skip_dec;
                end else if (skip_reg == EXT_LEN_LO) begin
                    pc_next = '0;
                    if (ext_words != 16'd0) begin
                        phase_next = PH_EXT_BODY;
                        skip_next  = {ext_words, 2'b00};
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    skip_next = skip_dec;
                end
            end
            PH_EXT_BODY: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                fwd = 1'b1;
                if (pc_reg != PLEN_MAX) begin
                    pc_next = pc_reg + PLEN_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (count_next < FIXED_HEADER_BYTES) begin
            status = ST_SHORT;
        end else if (phase_next == PH_DISCARD) begin
            status = ST_BAD_VERSION;
        end else if (phase_next == PH_PAYLOAD) begin
            status = ST_OK;
        end else begin
            status = ST_SHORT;
        end

        has_result = fwd || item.last_byte;

        res = '0;
        if (fwd) begin
            res.byte_valid   = 1'b1;
            res.payload_byte = b;
        end
        if (item.last_byte) begin
            res.end_of_packet = 1'b1;
            res.status        = status;
            if (status == ST_OK) begin
                res.marker         = first_next[7];
                res.payload_type   = first_next[6:0];
                res.sequence_res   = seq_next;
                res.timestamp      = time_next;
                res.ssrc           = source_next;
                res.payload_length = pc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last_byte)) begin
            phase_reg  <= PH_FIXED;
            count_reg  <= '0;
            first_reg  <= '0;
            seq_reg    <= '0;
            time_reg   <= '0;
            source_reg <= '0;
            skip_reg   <= '0;
            pc_reg     <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            seq_reg    <= seq_next;
            time_reg   <= time_next;
            source_reg <= source_next;
            skip_reg   <= skip_next;
            pc_reg     <= pc_next;
        end
    end

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> count_reg == '0 && phase_reg == PH_FIXED)
        else $error("parser did not restart after final byte");

    a_fwd_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res.byte_valid |-> phase_reg == PH_PAYLOAD)
        else $error("payload byte forwarded outside payload phase");

    a_plen_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.last_byte && phase_reg == PH_PAYLOAD
        |=> pc_reg >= $past(pc_reg) && pc_reg != '0)
        else $error("payload length went backward");

endmodule

// ===== src/rhp_output_stage.sv =====
// Result register toward the downstream receiver.
`timescale 1ns / 1ps

module rhp_output_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  rhp_pkg::res_t res,
    output logic          out_free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rhp_pkg::res_t m_res
);
    import rhp_pkg::*;

    logic m_valid_reg;
    res_t res_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while stalled");

endmodule

// ===== src/rtp_header_parser.sv =====
// Top level of the RTP header parser.
`timescale 1ns / 1ps

// RTP receive header parser.
// Input channel (s_): one packet byte per item in s_tdata[7:0], s_tlast on the
// final byte of the packet. Output channel (m_): one item per payload byte and
// one for the final byte; header, CSRC and extension bytes produce nothing
// unless they end the packet. m_tuser flags a valid payload byte in m_tdata[7:0];
// m_tlast marks the end-of-packet item, which carries status and header fields.
// An accepted byte is held in the input register, its result then in the
// result register. Throughput: one byte per cycle while m_tready is high; the
// phase update between the two registers is combinational. The input side keeps
// accepting while a result waits, as long as the item taking the core's slot
// either has no result or the result register is free.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of a fixed header. When m_tready is low, the result is
// held, an input byte with a result waits; s_tready drops once both are full.
// Status: 0 ok, 1 packet too short or cut inside CSRC/extension, 2 bad version
// (rest of that packet discarded). Payload length saturates at 65535.
module rtp_header_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] data_byte
    input  logic                         s_tlast,  // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] payload_byte, [9:8] status, [10] marker, [17:11] payload_type,
    // [33:18] sequence_res, [65:34] timestamp, [97:66] ssrc,
    // [113:98] payload_length, [119:114] zero
    output logic [rhp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser,  // [0] byte_valid
    output logic                         m_tlast   // end_of_packet
);
    import rhp_pkg::*;

    item_t s_item;
    item_t in_item;
    logic  in_valid;
    logic  advance;
    logic  has_result;
    logic  out_free;
    logic  load;
    res_t  core_res;
    res_t  m_res;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    assign advance = in_valid && (!has_result || out_free);
    assign load    = advance && has_result;

    rhp_input_stage u_input (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    rhp_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .item       (in_item),
        .has_result (has_result),
        .res        (core_res)
    );

    rhp_output_stage u_output (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (core_res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tuser = m_res.byte_valid;
    assign m_tlast = m_res.end_of_packet;
    assign m_tdata = {6'b000000,
                      m_res.payload_length,
                      m_res.ssrc,
                      m_res.timestamp,
                      m_res.sequence_res,
                      m_res.payload_type,
                      m_res.marker,
                      m_res.status,
                      m_res.payload_byte};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the RTP header parser.
`timescale 1ns / 1ps

module testbench;
    import rhp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // Packet description used by the stimulus tasks.
    typedef struct {
        logic [1:0]  version;
        logic        pad;
        logic        ext_flag;
        logic [3:0]  csrc_count;
        logic        marker;
        logic [6:0]  ptype;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [15:0] ext_words;
        int          body_len;
        int          cut_len;  // 0 sends the whole packet, else at most this many bytes
    } rtp_pkt_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int src_idle_pct = 35;
    int snk_idle_pct = 35;
    int err_count    = 0;
    int cycle_count  = 0;

    res_t       parser_out_q[$];
    logic [7:0] pkt_bytes[$];

    // Parser state mirror
    phase_t        p_phase;
    logic [17:0]   p_count;
    logic [15:0]   p_hdr01;
    logic [15:0]   p_seq;
    logic [31:0]   p_ts;
    logic [31:0]   p_ssrc;
    logic [17:0]   p_skip;
    logic [15:0]   p_plen;

    rtp_header_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic clear_parser_state();
        p_phase = PH_FIXED;
        p_count = '0;
        p_hdr01 = '0;
        p_seq   = '0;
        p_ts    = '0;
        p_ssrc  = '0;
        p_skip  = '0;
        p_plen  = '0;
    endtask

    task automatic leave_csrc();
        if (p_hdr01[12]) begin
            p_phase = PH_EXT_HDR;
            p_skip  = EXT_HDR_BYTES;
        end else begin
            p_phase = PH_PAYLOAD;
        end
    endtask

    // Advance the parser mirror by one accepted byte; queue the item it yields.
    task automatic parse_rtp_byte(input logic [7:0] b, input logic is_last);
        logic [17:0] idx;
        logic        fwd;
        logic [15:0] words;
        res_t        r;
        idx = p_count;
        fwd = 1'b0;
        if (p_count != COUNT_MAX) p_count++;
        case (p_phase)
            PH_FIXED: begin
                if (idx == 0) begin
                    p_hdr01 = {b, 8'h00};
                    if (b[7:6] != RTP_VERSION) p_phase = PH_DISCARD;
                end else if (idx == 1) begin
                    p_hdr01[7:0] = b;
                end else if (idx < IDX_SEQ_END) begin
                    p_seq = {p_seq[7:0], b};
                end else if (idx < IDX_TS_END) begin
                    p_ts = {p_ts[23:0], b};
                end else begin
                    p_ssrc = {p_ssrc[23:0], b};
                end
                if (p_phase == PH_FIXED && idx == IDX_HDR_LAST) begin
                    if (p_hdr01[11:8] != 4'd0) begin
                        p_phase = PH_CSRC;
                        p_skip  = {12'd0, p_hdr01[11:8], 2'b00};
                    end else begin
                        leave_csrc();
                    end
                end
            end
            PH_CSRC: begin
                if (p_skip != 0) p_skip--;
                if (p_skip == 0) leave_csrc();
            end
            PH_EXT_HDR: begin
                if (p_skip == EXT_LEN_LO) begin
                    // low length byte ends the extension header, no countdown
                    words  = {p_plen[7:0], b};
                    p_plen = '0;
                    if (words != 0) begin
                        p_phase = PH_EXT_BODY;
                        p_skip  = {words, 2'b00};
                    end else begin
                        p_phase = PH_PAYLOAD;
                    end
                end else begin
                    if (p_skip == EXT_LEN_HI) p_plen = {8'h00, b};
                    if (p_skip != 0) p_skip--;
                end
            end
            PH_EXT_BODY: begin
                if (p_skip != 0) p_skip--;
                if (p_skip == 0) p_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                fwd = 1'b1;
                if (p_plen != PLEN_MAX) p_plen++;
            end
            default: ;
        endcase

        if (fwd || is_last) begin
            r = '0;
            if (fwd) begin
                r.byte_valid   = 1'b1;
                r.payload_byte = b;
            end
            if (is_last) begin
                r.end_of_packet = 1'b1;
                if (p_count < FIXED_HEADER_BYTES)  r.status = ST_SHORT;
                else if (p_phase == PH_DISCARD)    r.status = ST_BAD_VERSION;
                else if (p_phase == PH_PAYLOAD)    r.status = ST_OK;
                else                               r.status = ST_SHORT;
                if (r.status == ST_OK) begin
                    r.marker         = p_hdr01[7];
                    r.payload_type   = p_hdr01[6:0];
                    r.sequence_res   = p_seq;
                    r.timestamp      = p_ts;
                    r.ssrc           = p_ssrc;
                    r.payload_length = p_plen;
                end
                clear_parser_state();
            end
            parser_out_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic match_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic compare_result();
        res_t want;
        if (parser_out_q.size() == 0) begin
            report_mismatch("unexpected item", {31'd0, m_tlast}, 32'd0);
        end else begin
            want = parser_out_q.pop_front();
            match_field("byte_valid",     {31'd0, m_tuser},     {31'd0, want.byte_valid});
            match_field("payload_byte",   {24'd0, m_tdata[7:0]}, {24'd0, want.payload_byte});
            match_field("end_of_packet",  {31'd0, m_tlast},     {31'd0, want.end_of_packet});
            match_field("status",         {30'd0, m_tdata[9:8]}, {30'd0, want.status});
            match_field("marker",         {31'd0, m_tdata[10]}, {31'd0, want.marker});
            match_field("payload_type",   {25'd0, m_tdata[17:11]}, {25'd0, want.payload_type});
            match_field("sequence_res",   {16'd0, m_tdata[33:18]}, {16'd0, want.sequence_res});
            match_field("timestamp",      m_tdata[65:34],       want.timestamp);
            match_field("ssrc",           m_tdata[97:66],       want.ssrc);
            match_field("payload_length", {16'd0, m_tdata[113:98]},
                        {16'd0, want.payload_length});
        end
    endtask

    // Result side: random stalls set at the falling edge, items taken at the rising edge.
    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) compare_result();
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_rtp_byte(b, is_last);
    endtask

    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (parser_out_q.size() != 0) @(posedge aclk);
    endtask

    task automatic add_byte(input logic [7:0] b, input int cap);
        if (pkt_bytes.size() < cap) pkt_bytes.push_back(b);
    endtask

    task automatic send_rtp(input rtp_pkt_t p);
        int cap;
        int i;
        cap = (p.cut_len > 0) ? p.cut_len : 32'h7FFF_FFFF;
        pkt_bytes.delete();
        add_byte({p.version, p.pad, p.ext_flag, p.csrc_count}, cap);
        add_byte({p.marker, p.ptype}, cap);
        add_byte(p.seq[15:8], cap);
        add_byte(p.seq[7:0], cap);
        for (i = 3; i >= 0; i--) add_byte(p.ts[8*i +: 8], cap);
        for (i = 3; i >= 0; i--) add_byte(p.ssrc[8*i +: 8], cap);
        for (i = 0; i < 4 * p.csrc_count && pkt_bytes.size() < cap; i++)
            add_byte(8'($urandom_range(255)), cap);
        if (p.ext_flag) begin
            add_byte(8'($urandom_range(255)), cap);
            add_byte(8'($urandom_range(255)), cap);
            add_byte(p.ext_words[15:8], cap);
            add_byte(p.ext_words[7:0], cap);
            for (i = 0; i < 4 * p.ext_words && pkt_bytes.size() < cap; i++)
                add_byte(8'($urandom_range(255)), cap);
        end
        for (i = 0; i < p.body_len && pkt_bytes.size() < cap; i++)
            add_byte(8'($urandom_range(255)), cap);
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    function automatic rtp_pkt_t random_rtp();
        rtp_pkt_t p;
        p.version     = RTP_VERSION;
        p.pad         = 1'($urandom_range(1));
        p.ext_flag    = 1'($urandom_range(1));
        p.csrc_count  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        p.marker      = 1'($urandom_range(1));
        p.ptype       = 7'($urandom_range(127));
        p.seq         = 16'($urandom_range(16'hFFFF));
        p.ts          = $urandom;
        p.ssrc        = $urandom;
        p.ext_words   = 16'($urandom_range(3));
        p.body_len    = $urandom_range(12);
        p.cut_len     = 0;
        return p;
    endfunction

    // Header that ends exactly on the final byte, fields at both extremes, then a packet with one payload byte.
    task automatic test_header_extremes();
        rtp_pkt_t p;
        p = random_rtp();
        p.ext_flag = 1'b0; p.csrc_count = 4'd0; p.body_len = 0;
        p.marker = 1'b0; p.ptype = 7'd0; p.seq = 16'h0000;
        p.ts = 32'h0; p.ssrc = 32'h0; p.pad = 1'b0;
        send_rtp(p);
        p.marker = 1'b1; p.ptype = 7'h7F; p.seq = 16'hFFFF;
        p.ts = 32'hFFFF_FFFF; p.ssrc = 32'hFFFF_FFFF; p.pad = 1'b1;
        send_rtp(p);
        p = random_rtp();
        p.body_len = 1;
        send_rtp(p);
    endtask

    task automatic test_short_packets();
        rtp_pkt_t p;
        p = random_rtp();
        p.cut_len = 1;  send_rtp(p);
        p.cut_len = 2;  send_rtp(p);
        p.cut_len = 11; send_rtp(p);
        p.version = 2'd1;
        p.cut_len = 1;  send_rtp(p);
        p.cut_len = 11; send_rtp(p);
    endtask

    task automatic test_bad_version();
        rtp_pkt_t p;
        int v;
        for (v = 0; v < 4; v++) begin
            if (v != RTP_VERSION) begin
                p = random_rtp();
                p.version = 2'(v);
                p.body_len = 6;
                send_rtp(p);
            end
        end
        // status flips from short to bad version at the header boundary
        p = random_rtp();
        p.version = 2'd3;
        p.cut_len = 12;
        send_rtp(p);
    endtask

    task automatic test_csrc_and_extension();
        rtp_pkt_t p;
        p = random_rtp();
        p.csrc_count = 4'd15; p.ext_flag = 1'b1; p.ext_words = 16'd0; p.body_len = 3;
        send_rtp(p);
        p.csrc_count = 4'd1; p.ext_words = 16'd1;
        send_rtp(p);
        // length high byte set; packet ends inside the long extension body
        p.csrc_count = 4'd0; p.ext_words = 16'h0100; p.body_len = 2; p.cut_len = 40;
        send_rtp(p);
        // cut inside CSRC list, extension header and extension body
        p = random_rtp();
        p.csrc_count = 4'd3; p.cut_len = 16;
        send_rtp(p);
        p.csrc_count = 4'd0; p.ext_flag = 1'b1; p.cut_len = 14;
        send_rtp(p);
        p.ext_words = 16'hFFFF; p.cut_len = 30;
        send_rtp(p);
        // extension ends on the final byte
        p.ext_words = 16'd2; p.body_len = 0; p.cut_len = 0;
        send_rtp(p);
    endtask

    // Longer payload during the stretch with no idling on either side.
    task automatic test_long_payload();
        rtp_pkt_t p;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        p = random_rtp();
        p.body_len = 40;
        send_rtp(p);
        src_idle_pct = 35;
        snk_idle_pct = 35;
    endtask

    task automatic test_random_traffic();
        rtp_pkt_t p;
        int sent_bytes;
        int pkts;
        int kind;
        int n;
        int i;
        sent_bytes = 0;
        pkts = 0;
        while (sent_bytes < 60 || pkts < 3) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                send_rtp(random_rtp());
                sent_bytes += pkt_bytes.size();
            end else if (kind < 85) begin
                p = random_rtp();
                p.cut_len = $urandom_range(40, 1);
                send_rtp(p);
                sent_bytes += pkt_bytes.size();
            end else begin
                n = $urandom_range(20, 1);
                for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
                sent_bytes += n;
            end
            pkts++;
            if ($urandom_range(7) == 0) drain_outputs();
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        clear_parser_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_header_extremes();
        test_short_packets();
        test_bad_version();
        test_csrc_and_extension();
        drain_outputs();
        test_long_payload();
        test_random_traffic();

        drain_outputs();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
